// File: rtl/core/prvenc_pkg.sv
// Shared widths, constants and codes for the posting record varint encoder.
// No dependencies; read by the channel interfaces and the core.
package prvenc_pkg;

  localparam int FIELD_W         = 32;  // width of every record field
  localparam int BYTE_W          = 8;   // one coded byte
  localparam int DIGIT_W         = 7;   // payload bits per varint byte
  localparam int VALUE_WIDTH_DEF = 32;  // default coded value width
  localparam int VALUE_WIDTH_MAX = 32;  // coded width is clamped to this
  localparam int HIT_SPLIT       = 24;  // single hit split point

  localparam logic [63:0] HIT_LOW_MASK = 64'h0000_0000_00ff_ffff;

  // record kinds
  localparam logic OP_DOC  = 1'b0;
  localparam logic OP_WORD = 1'b1;

endpackage

// File: rtl/core/prvenc_if.sv
// Valid/ready channel interfaces for the posting record encoder.
// Depends on prvenc_pkg for field and byte widths.
interface prvenc_in_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic                            list_start;
  logic [prvenc_pkg::FIELD_W-1:0]  doc_id;
  logic [prvenc_pkg::FIELD_W-1:0]  field_mask;
  logic [prvenc_pkg::FIELD_W-1:0]  hit_count;
  logic [prvenc_pkg::FIELD_W-1:0]  hit_value;
  logic [prvenc_pkg::FIELD_W-1:0]  word_id;
  logic [prvenc_pkg::FIELD_W-1:0]  doc_total;
  logic [prvenc_pkg::FIELD_W-1:0]  doc_offset;

  modport source (output valid, opcode, list_start, doc_id, field_mask, hit_count,
                  hit_value, word_id, doc_total, doc_offset, input ready);
  modport sink   (input valid, opcode, list_start, doc_id, field_mask, hit_count,
                  hit_value, word_id, doc_total, doc_offset, output ready);
endinterface

interface prvenc_out_if;
  logic                           valid;
  logic                           ready;
  logic [prvenc_pkg::BYTE_W-1:0]  out_byte;
  logic                           to_word_stream;
  logic                           last_byte;

  modport source (output valid, out_byte, to_word_stream, last_byte, input ready);
  modport sink   (input valid, out_byte, to_word_stream, last_byte, output ready);
endinterface

// File: rtl/core/posting_record_varint_encoder_core.sv
// Posting record varint encoder, top level.
// Depends on prvenc_pkg and the channel interfaces in prvenc_if.sv.
//
// Usage:
//   in_ch  : one posting record per request, document (opcode 0) or word
//            (opcode 1). Taken only while the encoder is idle.
//   out_ch : one coded varint byte per request, low 7 bits first, bit 7 set
//            while the same value continues. to_word_stream follows opcode,
//            last_byte marks the final byte of the record.
// Timing:
//   A record is taken in ST_IDLE, its first value is loaded in ST_LOAD and
//   its coded bytes (4 to 20 per record) are sent from ST_EMIT. A single
//   shifter/compare unit peels one 7-bit digit per cycle while out_ch is not
//   stalling; the next value is loaded (through one shared subtractor for the
//   word deltas) in the cycle that emits the previous value's last byte. The
//   first byte reaches out_ch through ST_LOAD, ST_EMIT and the output register.
// Stall: the output register holds its byte while out_ch.ready is low and
//   the sequencer waits; a new record is taken while the last byte waits.
// Reset: previous word id and doc offset go to zero, the encoder goes idle
//   and out_ch.valid drops.
module posting_record_varint_encoder_core #(
  parameter int VALUE_WIDTH = prvenc_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  prvenc_in_if.sink    in_ch,
  prvenc_out_if.source out_ch
);

  // coded width, clamped so a record never exceeds 20 bytes
  localparam int VW = (VALUE_WIDTH > prvenc_pkg::VALUE_WIDTH_MAX) ?
                      prvenc_pkg::VALUE_WIDTH_MAX : VALUE_WIDTH;
  localparam int DW = prvenc_pkg::DIGIT_W;

  localparam logic [VW-1:0] LOW_MASK = prvenc_pkg::HIT_LOW_MASK[VW-1:0];
  localparam logic [VW-1:0] ONE      = VW'(1);

  // field slots in coding order
  localparam logic [2:0] FLD_0 = 3'd0;  // doc id / word id delta
  localparam logic [2:0] FLD_1 = 3'd1;  // field mask / doc total
  localparam logic [2:0] FLD_2 = 3'd2;  // hit count
  localparam logic [2:0] FLD_3 = 3'd3;  // hit value (or low part) / offset delta
  localparam logic [2:0] FLD_4 = 3'd4;  // hit value high part (single hit)

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] fld_r, fld_nxt;
  logic [VW-1:0] value_r, value_nxt;
  logic [VW-1:0] prev_word_r, prev_word_nxt;
  logic [VW-1:0] prev_off_r, prev_off_nxt;
  logic out_valid_r, out_valid_nxt;

  // captured record
  logic          opcode_r;
  logic [VW-1:0] doc_id_r, field_mask_r, hit_count_r, hit_value_r;
  logic [VW-1:0] word_id_r, doc_total_r, doc_offset_r;

  // output payload
  logic [prvenc_pkg::BYTE_W-1:0] out_byte_r;
  logic                          out_last_r;
  logic                          out_stream_r;

  logic          in_take;
  logic          is_word;
  logic          single_hit;
  logic          can_push;
  logic          more;
  logic          last_fld;
  logic [2:0]    sel_idx;
  logic [VW-1:0] sub_a, sub_b, diff;
  logic [VW-1:0] sel_val;
  logic [prvenc_pkg::BYTE_W-1:0] cur_byte;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;

  assign is_word    = (opcode_r == prvenc_pkg::OP_WORD);
  assign single_hit = (hit_count_r == ONE);
  assign can_push   = !out_valid_r || out_ch.ready;

  // digit unit: current low digit and whether more digits remain
  assign more     = |value_r[VW-1:DW];
  assign cur_byte = {more, value_r[DW-1:0]};

  assign last_fld = (!is_word && single_hit) ? (fld_r == FLD_4) : (fld_r == FLD_3);

  // slot to load: first one right after capture, else the one after fld_r
  assign sel_idx = (state_r == ST_EMIT) ? (fld_r + 3'd1) : FLD_0;

  // shared subtractor for both word deltas, wraps mod 2^VW
  assign sub_a = (sel_idx == FLD_0) ? word_id_r   : doc_offset_r;
  assign sub_b = (sel_idx == FLD_0) ? prev_word_r : prev_off_r;
  assign diff  = sub_a - sub_b;

  always_comb begin
    case (sel_idx)
      FLD_0:   sel_val = is_word ? diff : doc_id_r;
      FLD_1:   sel_val = is_word ? doc_total_r : field_mask_r;
      FLD_2:   sel_val = hit_count_r;
      FLD_3: begin
        if (is_word) begin
          sel_val = diff;
        end else if (single_hit) begin
          sel_val = hit_value_r & LOW_MASK;
        end else begin
          sel_val = hit_value_r;
        end
      end
      FLD_4:   sel_val = hit_value_r >> prvenc_pkg::HIT_SPLIT;
      default: sel_val = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fld_nxt       = fld_r;
    value_nxt     = value_r;
    prev_word_nxt = prev_word_r;
    prev_off_nxt  = prev_off_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          // start flag only matters on word records
          if (in_ch.opcode == prvenc_pkg::OP_WORD && in_ch.list_start) begin
            prev_word_nxt = '0;
            prev_off_nxt  = '0;
          end
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        value_nxt = sel_val;
        fld_nxt   = FLD_0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (can_push) begin
          out_valid_nxt = 1'b1;
          if (more) begin
            value_nxt = value_r >> DW;
          end else if (last_fld) begin
            state_nxt = ST_IDLE;
            if (is_word) begin
              prev_word_nxt = word_id_r;
              prev_off_nxt  = doc_offset_r;
            end
          end else begin
            value_nxt = sel_val;
            fld_nxt   = fld_r + 3'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fld_r       <= FLD_0;
      prev_word_r <= '0;
      prev_off_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fld_r       <= fld_nxt;
      prev_word_r <= prev_word_nxt;
      prev_off_r  <= prev_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (in_take) begin
      opcode_r     <= in_ch.opcode;
      doc_id_r     <= in_ch.doc_id[VW-1:0];
      field_mask_r <= in_ch.field_mask[VW-1:0];
      hit_count_r  <= in_ch.hit_count[VW-1:0];
      hit_value_r  <= in_ch.hit_value[VW-1:0];
      word_id_r    <= in_ch.word_id[VW-1:0];
      doc_total_r  <= in_ch.doc_total[VW-1:0];
      doc_offset_r <= in_ch.doc_offset[VW-1:0];
    end
    if (state_r == ST_EMIT && can_push) begin
      out_byte_r   <= cur_byte;
      out_last_r   <= !more && last_fld;
      out_stream_r <= opcode_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.to_word_stream = out_stream_r;
  assign out_ch.last_byte      = out_last_r;

endmodule

// File: verif/posting_record_varint_encoder_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for posting_record_varint_encoder_core: predicts every coded byte
// per record request and compares against out_ch. Depends on prvenc_pkg and prvenc_if.sv.
module posting_record_varint_encoder_core_tb;
  import prvenc_pkg::*;

  // Coded width as the block clamps it; all values and deltas wrap to this.
  localparam int CODE_W =
    (VALUE_WIDTH_DEF < 1) ? 1 : ((VALUE_WIDTH_DEF > VALUE_WIDTH_MAX) ? VALUE_WIDTH_MAX
                                                                     : VALUE_WIDTH_DEF);
  localparam logic [FIELD_W-1:0] VALUE_MASK = FIELD_W'((64'd1 << CODE_W) - 1);
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request on either channel
  localparam int SETTLE_CYCLES  = 40;    // > worst record latency plus margin
  localparam int MAX_SHOWN      = 10;

  typedef struct {
    logic               opcode;
    logic               list_start;
    logic [FIELD_W-1:0] doc_id;
    logic [FIELD_W-1:0] field_mask;
    logic [FIELD_W-1:0] hit_count;
    logic [FIELD_W-1:0] hit_value;
    logic [FIELD_W-1:0] word_id;
    logic [FIELD_W-1:0] doc_total;
    logic [FIELD_W-1:0] doc_offset;
  } posting_rec_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              word_stream;
    logic              last;
  } coded_byte_t;

  // Tracks the delta state and the queue of bytes still owed by the encoder.
  class record_byte_checker;
    coded_byte_t        owed_bytes[$];
    logic [FIELD_W-1:0] last_word_id;
    logic [FIELD_W-1:0] last_doc_offset;
    int                 errors;

    function new();
      last_word_id    = '0;
      last_doc_offset = '0;
      errors          = 0;
    endfunction

    function int pending();
      return owed_bytes.size();
    endfunction

    // LEB128-style: low 7 bits first, bit 7 set while more digits follow.
    function void append_varint(logic [FIELD_W-1:0] value, logic stream);
      logic [FIELD_W-1:0] v;
      coded_byte_t        b;
      v = value & VALUE_MASK;
      do begin
        b.data        = {1'b0, v[DIGIT_W-1:0]};
        v             = v >> DIGIT_W;
        b.data[7]     = (v != '0);
        b.word_stream = stream;
        b.last        = 1'b0;
        owed_bytes.push_back(b);
      end while (v != '0);
    endfunction

    function void note_record(posting_rec_t r);
      logic [FIELD_W-1:0] hit;
      if (r.opcode == OP_DOC) begin
        // start flag is a don't-care here; state untouched
        append_varint(r.doc_id, OP_DOC);
        append_varint(r.field_mask, OP_DOC);
        append_varint(r.hit_count, OP_DOC);
        if ((r.hit_count & VALUE_MASK) == 1) begin
          hit = r.hit_value & VALUE_MASK;
          append_varint(hit & HIT_LOW_MASK[FIELD_W-1:0], OP_DOC);
          append_varint(hit >> HIT_SPLIT, OP_DOC);
        end else begin
          append_varint(r.hit_value, OP_DOC);
        end
      end else begin
        if (r.list_start) begin
          last_word_id    = '0;
          last_doc_offset = '0;
        end
        append_varint(r.word_id - last_word_id, OP_WORD);
        append_varint(r.doc_total, OP_WORD);
        append_varint(r.hit_count, OP_WORD);
        append_varint(r.doc_offset - last_doc_offset, OP_WORD);
        last_word_id    = r.word_id & VALUE_MASK;
        last_doc_offset = r.doc_offset & VALUE_MASK;
      end
      owed_bytes[owed_bytes.size() - 1].last = 1'b1;
    endfunction

    function void check_byte(coded_byte_t got);
      coded_byte_t want;
      if (owed_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: unexpected byte %02h stream %0b last %0b", $realtime,
                   got.data, got.word_stream, got.last);
      end else begin
        want = owed_bytes.pop_front();
        if (got.data !== want.data || got.word_stream !== want.word_stream ||
            got.last !== want.last) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: byte mismatch exp %02h/%0b/%0b got %02h/%0b/%0b", $realtime,
                     want.data, want.word_stream, want.last,
                     got.data, got.word_stream, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  prvenc_in_if  in_ch ();
  prvenc_out_if out_ch ();

  posting_record_varint_encoder_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  record_byte_checker tracker = new();

  // Idle knobs, changed per phase: percent of cycles the sender holds back
  // and the receiver drops ready.
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  // Running posting-list position, so most word requests form real lists.
  logic [FIELD_W-1:0] cur_word;
  logic [FIELD_W-1:0] cur_offset;
  logic [FIELD_W-1:0] cur_doc;

  posting_rec_t seen_rec;
  coded_byte_t  seen_byte;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready changes on the falling edge only.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor + watchdog. Both channels are sampled at the rising edge; input
  // fields only move on the falling edge, so the captures are stable.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen_rec.opcode     = in_ch.opcode;
        seen_rec.list_start = in_ch.list_start;
        seen_rec.doc_id     = in_ch.doc_id;
        seen_rec.field_mask = in_ch.field_mask;
        seen_rec.hit_count  = in_ch.hit_count;
        seen_rec.hit_value  = in_ch.hit_value;
        seen_rec.word_id    = in_ch.word_id;
        seen_rec.doc_total  = in_ch.doc_total;
        seen_rec.doc_offset = in_ch.doc_offset;
        tracker.note_record(seen_rec);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_byte.data        = out_ch.out_byte;
        seen_byte.word_stream = out_ch.to_word_stream;
        seen_byte.last        = out_ch.last_byte;
        tracker.check_byte(seen_byte);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("posting_record_varint_encoder_core_tb: done, errors");
        $finish;
      end
    end
  end

  // Value mix that hits every varint length: zero, all ones, powers of two
  // and one less than them, short and full random.
  function automatic logic [FIELD_W-1:0] rand_value();
    logic [FIELD_W-1:0] v;
    case ($urandom_range(5))
      0:       v = '0;
      1:       v = '1;
      2:       v = $urandom >> $urandom_range(31);
      3:       v = (32'd1 << $urandom_range(31)) - $urandom_range(1);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Unused fields of a record get random junk; the block must ignore them.
  function automatic posting_rec_t doc_rec(logic [FIELD_W-1:0] id, logic [FIELD_W-1:0] mask,
                                           logic [FIELD_W-1:0] hits, logic [FIELD_W-1:0] hv,
                                           logic start);
    posting_rec_t r;
    r.opcode     = OP_DOC;
    r.list_start = start;
    r.doc_id     = id;
    r.field_mask = mask;
    r.hit_count  = hits;
    r.hit_value  = hv;
    r.word_id    = $urandom;
    r.doc_total  = $urandom;
    r.doc_offset = $urandom;
    return r;
  endfunction

  function automatic posting_rec_t word_rec(logic start, logic [FIELD_W-1:0] id,
                                            logic [FIELD_W-1:0] docs, logic [FIELD_W-1:0] hits,
                                            logic [FIELD_W-1:0] offset);
    posting_rec_t r;
    r.opcode     = OP_WORD;
    r.list_start = start;
    r.doc_id     = $urandom;
    r.field_mask = $urandom;
    r.hit_count  = hits;
    r.hit_value  = $urandom;
    r.word_id    = id;
    r.doc_total  = docs;
    r.doc_offset = offset;
    return r;
  endfunction

  // One request on in_ch, preceded by a random gap. Each falling edge makes
  // exactly one assignment to valid.
  task automatic send_record(input posting_rec_t r);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      gap++;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= r.opcode;
    in_ch.list_start <= r.list_start;
    in_ch.doc_id     <= r.doc_id;
    in_ch.field_mask <= r.field_mask;
    in_ch.hit_count  <= r.hit_count;
    in_ch.hit_value  <= r.hit_value;
    in_ch.word_id    <= r.word_id;
    in_ch.doc_total  <= r.doc_total;
    in_ch.doc_offset <= r.doc_offset;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Sender goes quiet until every owed byte has been seen.
  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Mostly well-formed traffic: posting lists opened by a start word, word
  // requests with ascending ids and offsets, doc requests with rising ids
  // and frequent single hits. About a fifth is unstructured noise.
  task automatic random_phase(input int n_items);
    int           pick;
    posting_rec_t r;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        cur_word   = rand_value();
        cur_offset = rand_value();
        r = word_rec(1'b1, cur_word, rand_value(), rand_value(), cur_offset);
      end else if (pick < 42) begin
        cur_word   += ($urandom_range(3) == 0) ? rand_value() : $urandom_range(1, 300);
        cur_offset += ($urandom_range(3) == 0) ? rand_value() : $urandom_range(1, 5000);
        r = word_rec(1'b0, cur_word, rand_value(), rand_value(), cur_offset);
      end else if (pick < 80) begin
        cur_doc += $urandom_range(1, 1000);
        r = doc_rec(cur_doc, rand_value(),
                    ($urandom_range(99) < 40) ? 32'd1 : rand_value(), rand_value(),
                    1'($urandom_range(1)));
      end else begin
        r.opcode     = 1'($urandom_range(1));
        r.list_start = 1'($urandom_range(1));
        r.doc_id     = $urandom;
        r.field_mask = $urandom;
        r.hit_count  = ($urandom_range(3) == 0) ? 32'd1 : $urandom;
        r.hit_value  = $urandom;
        r.word_id    = $urandom;
        r.doc_total  = $urandom;
        r.doc_offset = $urandom;
      end
      send_record(r);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    quiet_cycles     = 0;
    cur_word         = '0;
    cur_offset       = '0;
    cur_doc          = '0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_DOC;
    in_ch.list_start = 1'b0;
    in_ch.doc_id     = '0;
    in_ch.field_mask = '0;
    in_ch.hit_count  = '0;
    in_ch.hit_value  = '0;
    in_ch.word_id    = '0;
    in_ch.doc_total  = '0;
    in_ch.doc_offset = '0;
    out_ch.ready     = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, digit boundaries, the single-hit split,
    // wrapping deltas and the start flag on both record kinds.
    send_record(doc_rec('0, '0, '0, '0, 1'b0));                       // all zero -> 1 byte each
    send_record(doc_rec('1, '1, '1, '1, 1'b0));                       // longest doc record
    send_record(doc_rec(32'd127, 32'd128, 32'd1, '1, 1'b0));          // split, both halves max
    send_record(doc_rec(32'd16383, 32'd16384, 32'd1, '0, 1'b0));      // split of zero
    send_record(doc_rec(32'h001f_ffff, 32'h0020_0000, 32'd1, 32'h00ff_ffff, 1'b0));
    send_record(doc_rec(32'h0fff_ffff, 32'h1000_0000, 32'd1, 32'h0100_0000, 1'b0));
    send_record(doc_rec(32'd1, 32'd2, 32'd2, 32'h8000_0000, 1'b0));   // two hits: no split
    send_record(word_rec(1'b1, 32'd5, 32'd1, 32'd1, 32'd100));
    send_record(word_rec(1'b0, 32'd3, '1, '0, 32'd50));               // both deltas go negative
    send_record(doc_rec(32'd7, 32'd1, 32'd3, 32'd9, 1'b1));           // start on doc: no clear
    send_record(word_rec(1'b0, 32'd3, '0, '1, 32'd50));               // zero deltas
    send_record(word_rec(1'b0, '1, 32'd128, 32'd127, '1));
    send_record(word_rec(1'b0, '0, 32'd1, 32'd1, '0));                // wrap past max -> 1
    send_record(word_rec(1'b1, '0, '0, '0, '0));                      // shortest word record
    send_record(word_rec(1'b1, '1, '1, '1, '1));                      // longest word record
    send_record(word_rec(1'b0, 32'h8000_0000, 32'd5, 32'd1, 32'h8000_0000));
    send_record(doc_rec(32'h8000_0000, 32'h5555_5555, 32'haaaa_aaaa, 32'd1, 1'b0));
    send_record(doc_rec(32'h7fff_ffff, 32'haaaa_aaaa, 32'd1, 32'h5555_5555, 1'b1));
    hold_until_drained();

    // Random traffic under each idling mix.
    random_phase(40);
    send_idle_pct  = 70;
    random_phase(40);
    hold_until_drained();   // pause with nothing in flight, then resume
    send_idle_pct  = 0;
    recv_stall_pct = 70;
    random_phase(40);
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    random_phase(40);
    hold_until_drained();

    // Let any stray trailing byte show up before deciding.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("posting_record_varint_encoder_core_tb: done, clean");
    end else begin
      $display("posting_record_varint_encoder_core_tb: done, errors");
    end
    $finish;
  end

endmodule
